// File: src/mlpf_pkg.sv
`default_nettype none
package mlpf_pkg;

   // Width of the sample and result fields on the ports.
   localparam int FIELD_W = 16;
   // Widest weighted sum plus rounding term: 9 * (2^16 - 1) + 4 fits in 20 bits.
   localparam int SUM_W = FIELD_W + 4;
   // Up to four results per sample, counted 0..4.
   localparam int SLOTS = 4;
   localparam int CNT_W = 3;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_MEDIAN_ENABLE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOWPASS_ENABLE = 1'b1;

   typedef enum logic [1:0] {
      CODE_PASS,
      CODE_DIV9,
      CODE_DIV8,
      CODE_DIV6
   } div_code_type;

   // One pending result: rounded sum and the divisor it still needs.
   typedef struct packed {
      logic [SUM_W-1:0] sum;
      div_code_type     code;
      logic             last;
   } entry_type;

   typedef struct packed {
      entry_type [SLOTS-1:0] slot;
      logic [CNT_W-1:0]      count;
   } batch_type;

endpackage
`default_nettype wire

// File: src/mlpf_if.sv
`default_nettype none
interface mlpf_req_if;
   import mlpf_pkg::*;

   logic               valid;
   logic               ready;
   logic [FIELD_W-1:0] sample;
   logic               pile_end;

   modport source (output valid, sample, pile_end, input ready);
   modport sink (input valid, sample, pile_end, output ready);
endinterface

interface mlpf_rsp_if;
   import mlpf_pkg::*;

   logic               valid;
   logic               ready;
   logic [FIELD_W-1:0] filtered;
   logic               last_out;

   modport source (output valid, filtered, last_out, input ready);
   modport sink (input valid, filtered, last_out, output ready);
endinterface
`default_nettype wire

// File: src/mlpf_drain.sv
`default_nettype none
module mlpf_drain (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  mlpf_pkg::batch_type batch,
   output logic                free,
   mlpf_rsp_if.source          rsp_bus
);
   import mlpf_pkg::*;

   // Round-up reciprocals: the error term stays below 2^(SHIFT-SUM_W), so the
   // quotient is exact for every sum that fits in SUM_W bits.
   localparam int SHIFT = SUM_W + 3;
   localparam int PROD_W = 2 * SUM_W + 2;
   localparam logic [SUM_W:0] RECIP9 = (SUM_W + 1)'(((1 << SHIFT) + 8) / 9);
   localparam logic [SUM_W:0] RECIP6 = (SUM_W + 1)'(((1 << SHIFT) + 5) / 6);

   batch_type          batch_ff, batch_in;
   logic [CNT_W-1:0]   head_ff, head_in;
   logic               out_valid_ff, out_valid_in;
   logic [FIELD_W-1:0] out_data_ff, out_data_in;
   logic               out_last_ff, out_last_in;

   entry_type          head_entry;
   logic               pending;
   logic               take;
   logic [SUM_W:0]     recip;
   logic [PROD_W-1:0]  product;
   logic [FIELD_W-1:0] quotient;

   assign head_entry = batch_ff.slot[head_ff[1:0]];
   assign pending    = (head_ff != batch_ff.count);
   assign take       = pending && (!out_valid_ff || rsp_bus.ready);
   // Free when nothing is left, or the last entry moves out this cycle.
   assign free       = !pending || (take && ((head_ff + CNT_W'(1)) == batch_ff.count));

   assign recip   = (head_entry.code == CODE_DIV9) ? RECIP9 : RECIP6;
   assign product = PROD_W'(head_entry.sum) * PROD_W'(recip);

   always_comb begin
      unique case (head_entry.code)
         CODE_PASS: begin
            quotient = head_entry.sum[FIELD_W-1:0];
         end
         CODE_DIV8: begin
            quotient = head_entry.sum[3 +: FIELD_W];
         end
         CODE_DIV9, CODE_DIV6: begin
            quotient = product[SHIFT +: FIELD_W];
         end
      endcase
   end

   always_comb begin
      batch_in     = batch_ff;
      head_in      = head_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;
      if (take) begin
         head_in      = head_ff + CNT_W'(1);
         out_valid_in = 1'b1;
         out_data_in  = quotient;
         out_last_in  = head_entry.last;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
      if (load) begin
         batch_in = batch;
         head_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         batch_ff     <= '0;
         head_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         batch_ff     <= batch_in;
         head_ff      <= head_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_bus.valid    = out_valid_ff;
   assign rsp_bus.filtered = out_data_ff;
   assign rsp_bus.last_out = out_last_ff;

endmodule
`default_nettype wire

// File: src/median_lowpass_pile_filter_top.sv
// Output path: a result enters the result queue on the transfer of the sample that completes it.
// Throughput: one sample per cycle while each sample yields at most one result and rsp_bus is
// ready; a pile-ending sample yields up to four, sent one per cycle from the result queue while
// rsp_bus is ready, and input waits until they are out. The single result divider sets this rate.
// Reset (synchronous, active high) clears the enables, windows, position and queue.
`default_nettype none
module median_lowpass_pile_filter_top #(
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [mlpf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic                             csr_wdata,
   mlpf_req_if.sink                         req_bus,
   mlpf_rsp_if.source                       rsp_bus
);
   import mlpf_pkg::*;

   localparam logic [2:0] POS_MAX = 3'd7;

   typedef logic [SAMPLE_WIDTH-1:0] samp_type;
   typedef samp_type [3:0] win_type;
   typedef samp_type [1:0] raw_type;

   typedef struct packed {
      entry_type [2:0] slot;
      logic [1:0]      count;
      win_type         win;
   } feed_type;

   logic       median_enable_ff, median_enable_in;
   logic       lowpass_enable_ff, lowpass_enable_in;
   logic       med_on_ff, med_on_in;
   logic       lp_on_ff, lp_on_in;
   logic [2:0] pos_ff, pos_in;
   raw_type    raw_ff, raw_in;
   win_type    win_ff, win_in;

   logic       free;
   logic       accept;
   logic       first;
   logic       med;
   logic       lp;
   logic       last;
   samp_type   x;
   samp_type   mid;
   feed_type   feed_a;
   feed_type   feed_b;
   batch_type  batch;

   function automatic entry_type mk_entry(input logic [SUM_W-1:0] sum,
                                          input div_code_type code, input logic last_flag);
      entry_type e;
      e.sum  = sum;
      e.code = code;
      e.last = last_flag;
      return e;
   endfunction

   function automatic samp_type med3(input samp_type a, input samp_type b, input samp_type c);
      samp_type lo;
      samp_type hi;
      samp_type m;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      m  = (hi < c) ? hi : c;
      return (lo > m) ? lo : m;
   endfunction

   // Smoothing stage for one median-stage value c at pile index j.
   function automatic feed_type smooth_feed(input samp_type c, input logic [2:0] j,
                                            input logic last_flag, input logic lp_flag,
                                            input win_type w);
      feed_type         f;
      logic [SUM_W-1:0] c_s;
      logic [SUM_W-1:0] w0_s;
      logic [SUM_W-1:0] w1_s;
      logic [SUM_W-1:0] w2_s;
      logic [SUM_W-1:0] w3_s;
      f     = '0;
      f.win = w;
      c_s   = SUM_W'(c);
      w0_s  = SUM_W'(w[0]);
      w1_s  = SUM_W'(w[1]);
      w2_s  = SUM_W'(w[2]);
      w3_s  = SUM_W'(w[3]);
      if (!lp_flag) begin
         f.slot[0] = mk_entry(c_s, CODE_PASS, last_flag);
         f.count   = 2'd1;
      end else if (last_flag && (j < 3'd3)) begin
         // Short pile: release what is held unchanged.
         if (j >= 3'd2) begin
            f.slot[f.count] = mk_entry(w1_s, CODE_PASS, 1'b0);
            f.count         = f.count + 2'd1;
         end
         if (j >= 3'd1) begin
            f.slot[f.count] = mk_entry(w0_s, CODE_PASS, 1'b0);
            f.count         = f.count + 2'd1;
         end
         f.slot[f.count] = mk_entry(c_s, CODE_PASS, 1'b1);
         f.count         = f.count + 2'd1;
      end else begin
         if (j == 3'd2) begin
            f.slot[f.count] = mk_entry(SUM_W'(3) * w1_s + SUM_W'(2) * w0_s + c_s
                                       + SUM_W'(3), CODE_DIV6, 1'b0);
            f.count         = f.count + 2'd1;
         end else if (j == 3'd3) begin
            f.slot[f.count] = mk_entry(SUM_W'(2) * w2_s + SUM_W'(3) * w1_s
                                       + SUM_W'(2) * w0_s + c_s + SUM_W'(4),
                                       CODE_DIV8, 1'b0);
            f.count         = f.count + 2'd1;
         end else if (j >= 3'd4) begin
            f.slot[f.count] = mk_entry(w3_s + SUM_W'(2) * w2_s + SUM_W'(3) * w1_s
                                       + SUM_W'(2) * w0_s + c_s + SUM_W'(4),
                                       CODE_DIV9, 1'b0);
            f.count         = f.count + 2'd1;
         end
         if (last_flag) begin
            f.slot[f.count] = mk_entry(w2_s + SUM_W'(2) * w1_s + SUM_W'(3) * w0_s
                                       + SUM_W'(2) * c_s + SUM_W'(4), CODE_DIV8, 1'b0);
            f.count         = f.count + 2'd1;
            f.slot[f.count] = mk_entry(w1_s + SUM_W'(2) * w0_s + SUM_W'(3) * c_s
                                       + SUM_W'(3), CODE_DIV6, 1'b1);
            f.count         = f.count + 2'd1;
         end
         f.win = {w[2], w[1], w[0], c};
      end
      return f;
   endfunction

   assign accept        = req_bus.valid && free;
   assign req_bus.ready = free;

   assign first = (pos_ff == 3'd0);
   assign med   = first ? median_enable_ff : med_on_ff;
   assign lp    = first ? lowpass_enable_ff : lp_on_ff;
   assign x     = req_bus.sample[SAMPLE_WIDTH-1:0];
   assign last  = req_bus.pile_end;
   assign mid   = (pos_ff == 3'd1) ? raw_ff[0] : med3(raw_ff[1], raw_ff[0], x);

   always_comb begin
      feed_a     = '0;
      feed_a.win = win_ff;
      feed_b     = '0;
      feed_b.win = win_ff;
      if (!med) begin
         feed_b = smooth_feed(x, pos_ff, last, lp, win_ff);
      end else begin
         if (!first) begin
            feed_a = smooth_feed(mid, pos_ff - 3'd1, 1'b0, lp, win_ff);
         end
         if (last) begin
            feed_b = smooth_feed(x, pos_ff, 1'b1, lp, feed_a.win);
         end else begin
            feed_b.win = feed_a.win;
         end
      end
   end

   // Queue the median-delayed result ahead of the end-of-pile flush.
   always_comb begin
      batch = '0;
      if (feed_a.count != 2'd0) begin
         batch.slot[0]   = feed_a.slot[0];
         batch.slot[3:1] = feed_b.slot;
      end else begin
         batch.slot[2:0] = feed_b.slot;
      end
      batch.count = CNT_W'(feed_a.count) + CNT_W'(feed_b.count);
   end

   always_comb begin
      median_enable_in  = median_enable_ff;
      lowpass_enable_in = lowpass_enable_ff;
      med_on_in         = med_on_ff;
      lp_on_in          = lp_on_ff;
      pos_in            = pos_ff;
      raw_in            = raw_ff;
      win_in            = win_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MEDIAN_ENABLE: begin
               median_enable_in = csr_wdata;
            end
            CSR_LOWPASS_ENABLE: begin
               lowpass_enable_in = csr_wdata;
            end
         endcase
      end
      if (accept) begin
         med_on_in = med;
         lp_on_in  = lp;
         raw_in    = {raw_ff[0], x};
         win_in    = feed_b.win;
         if (last) begin
            pos_in = 3'd0;
            raw_in = '0;
            win_in = '0;
         end else if (pos_ff < POS_MAX) begin
            pos_in = pos_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         median_enable_ff  <= 1'b0;
         lowpass_enable_ff <= 1'b0;
         med_on_ff         <= 1'b0;
         lp_on_ff          <= 1'b0;
         pos_ff            <= 3'd0;
         raw_ff            <= '0;
         win_ff            <= '0;
      end else begin
         median_enable_ff  <= median_enable_in;
         lowpass_enable_ff <= lowpass_enable_in;
         med_on_ff         <= med_on_in;
         lp_on_ff          <= lp_on_in;
         pos_ff            <= pos_in;
         raw_ff            <= raw_in;
         win_ff            <= win_in;
      end
   end

   mlpf_drain u_drain (
      .clock   (clock),
      .reset   (reset),
      .load    (accept),
      .batch   (batch),
      .free    (free),
      .rsp_bus (rsp_bus)
   );

endmodule
`default_nettype wire

// File: verif/tb_median_lowpass_pile_filter_top.sv
`default_nettype none
module tb_median_lowpass_pile_filter_top;
   import mlpf_pkg::*;

   localparam int IDLE_LIMIT = 2000;
   localparam int HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES = 8;

   typedef struct packed {
      logic [FIELD_W-1:0] sample;
      logic               pile_end;
   } sample_type;

   typedef struct packed {
      logic [FIELD_W-1:0] filtered;
      logic               last_out;
   } result_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic                 csr_wdata;

   mlpf_req_if req_bus ();
   mlpf_rsp_if rsp_bus ();

   median_lowpass_pile_filter_top uut (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus)
   );

   sample_type sample_queue[$];
   result_type filtered_queue[$];
   int      items_queued;
   int      items_sent;
   int      errors;
   int      holds_requested;
   bit      tx_gaps_on;
   bit      rx_stalls_on;

   // Predictor state: register values, enables latched per pile, windows.
   logic                med_cfg;
   logic                lp_cfg;
   logic                med_pile;
   logic                lp_pile;
   logic [FIELD_W-1:0]  raw_win [2];
   logic [FIELD_W-1:0]  med_win [4];
   logic [2:0]          pile_pos;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return $urandom_range(1, 2);
      end else if (r < 92) begin
         return $urandom_range(3, 6);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic void expect_result(input logic [FIELD_W-1:0] v, input bit last);
      result_type r;
      r.filtered = v;
      r.last_out = last;
      filtered_queue.push_back(r);
   endfunction

   function automatic logic [FIELD_W-1:0] median_of_three(input logic [FIELD_W-1:0] a,
                                                          input logic [FIELD_W-1:0] b,
                                                          input logic [FIELD_W-1:0] c);
      logic [FIELD_W-1:0] lo, hi, m;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      m = (hi < c) ? hi : c;
      return (lo > m) ? lo : m;
   endfunction

   // Smoothing stage: value c at pile index j.
   function automatic void lowpass_push(input logic [FIELD_W-1:0] c, input int j,
                                        input bit last);
      if (!lp_pile) begin
         expect_result(c, last);
         return;
      end
      if (last && j < 3) begin
         // too short to smooth: flush unchanged
         if (j >= 2) expect_result(med_win[1], 1'b0);
         if (j >= 1) expect_result(med_win[0], 1'b0);
         expect_result(c, 1'b1);
         return;
      end
      if (j == 2) begin
         expect_result(FIELD_W'((3 * med_win[1] + 2 * med_win[0] + c + 3) / 6), 1'b0);
      end else if (j == 3) begin
         expect_result(FIELD_W'((2 * med_win[2] + 3 * med_win[1] + 2 * med_win[0]
                                 + c + 4) / 8), 1'b0);
      end else if (j >= 4) begin
         expect_result(FIELD_W'((med_win[3] + 2 * med_win[2] + 3 * med_win[1]
                                 + 2 * med_win[0] + c + 4) / 9), 1'b0);
      end
      if (last) begin
         expect_result(FIELD_W'((med_win[2] + 2 * med_win[1] + 3 * med_win[0]
                                 + 2 * c + 4) / 8), 1'b0);
         expect_result(FIELD_W'((med_win[1] + 2 * med_win[0] + 3 * c + 3) / 6), 1'b1);
      end
      med_win[3] = med_win[2];
      med_win[2] = med_win[1];
      med_win[1] = med_win[0];
      med_win[0] = c;
   endfunction

   function automatic void predict_sample(input logic [FIELD_W-1:0] x, input bit pile_end);
      int k;
      k = int'(pile_pos);
      if (k == 0) begin
         med_pile = med_cfg;
         lp_pile = lp_cfg;
      end
      if (!med_pile) begin
         lowpass_push(x, k, pile_end);
      end else begin
         if (k >= 1) begin
            lowpass_push((k == 1) ? raw_win[0] : median_of_three(raw_win[1], raw_win[0], x),
                         k - 1, 1'b0);
         end
         if (pile_end) lowpass_push(x, k, 1'b1);
      end
      raw_win[1] = raw_win[0];
      raw_win[0] = x;
      if (pile_end) begin
         pile_pos = '0;
         raw_win[0] = '0;
         raw_win[1] = '0;
         for (int n = 0; n < 4; n++) med_win[n] = '0;
      end else if (pile_pos != 3'd7) begin
         pile_pos = pile_pos + 3'd1;
      end
   endfunction

   task automatic queue_sample(input logic [FIELD_W-1:0] v, input bit pile_end);
      sample_type s;
      s.sample = v;
      s.pile_end = pile_end;
      sample_queue.push_back(s);
      items_queued++;
   endtask

   task automatic add_random_pile();
      int len, style, pick, v;
      logic [FIELD_W-1:0] prev;
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
         len = $urandom_range(1, 3);
      end else if (pick < 90) begin
         len = $urandom_range(4, 12);
      end else begin
         len = $urandom_range(13, 30);
      end
      style = $urandom_range(0, 2);
      prev = FIELD_W'($urandom);
      for (int n = 0; n < len; n++) begin
         case (style)
            0: begin
               prev = FIELD_W'($urandom);
            end
            1: begin
               case ($urandom_range(0, 3))
                  0: prev = 16'h0000;
                  1: prev = 16'h0001;
                  2: prev = 16'hFFFE;
                  default: prev = 16'hFFFF;
               endcase
            end
            default: begin
               // drift around the previous value, clipped to range
               v = int'(prev) + int'($urandom_range(0, 128)) - 64;
               if (v < 0) v = 0;
               if (v > 65535) v = 65535;
               prev = v[FIELD_W-1:0];
            end
         endcase
         queue_sample(prev, n == len - 1);
      end
   endtask

   // Wait until all samples are taken and all results are in, then let the pipe drain.
   task automatic settle();
      while (items_sent != items_queued || filtered_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_config(input logic med, input logic lp);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_MEDIAN_ENABLE;
      csr_wdata <= med;
      @(posedge clock);
      csr_index <= CSR_LOWPASS_ENABLE;
      csr_wdata <= lp;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      med_cfg = med;
      lp_cfg = lp;
   endtask

   // Sample driver: predict on each transfer, then present the next queued sample.
   always @(posedge clock) begin : drive_samples
      int         tx_gap;
      sample_type nxt;
      if (reset) begin
         req_bus.valid <= 1'b0;
         tx_gap = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            predict_sample(req_bus.sample, req_bus.pile_end);
            items_sent++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (tx_gap > 0) begin
               tx_gap--;
               req_bus.valid <= 1'b0;
            end else if (sample_queue.size() != 0) begin
               nxt = sample_queue.pop_front();
               req_bus.sample <= nxt.sample;
               req_bus.pile_end <= nxt.pile_end;
               req_bus.valid <= 1'b1;
               if (tx_gaps_on && $urandom_range(0, 3) == 0) tx_gap = idle_length();
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: compare each transfer with the oldest expectation.
   always @(posedge clock) begin : check_results
      int         hold_left;
      int         stall_left;
      int         holds_served;
      result_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_left = 0;
         stall_left = 0;
         holds_served = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (filtered_queue.size() == 0) begin
               $display("%0t: unexpected result: expected none, actual filtered=%h last_out=%b",
                        $time, rsp_bus.filtered, rsp_bus.last_out);
               errors++;
            end else begin
               want = filtered_queue.pop_front();
               if (rsp_bus.filtered !== want.filtered) begin
                  $display("%0t: filtered mismatch: expected %h, actual %h",
                           $time, want.filtered, rsp_bus.filtered);
                  errors++;
               end
               if (rsp_bus.last_out !== want.last_out) begin
                  $display("%0t: last_out mismatch: expected %b, actual %b",
                           $time, want.last_out, rsp_bus.last_out);
                  errors++;
               end
            end
         end
         if (holds_requested != holds_served) begin
            holds_served++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (rx_stalls_on && $urandom_range(0, 7) == 0) begin
            stall_left = idle_length() - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      int idle_cycles;
      if (reset) begin
         idle_cycles = 0;
      end else if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
            $display("median_lowpass_pile_filter_top regression: fail");
            $finish;
         end
      end
   end

   initial begin : run_regression
      int first;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = CSR_MEDIAN_ENABLE;
      csr_wdata = 1'b0;
      req_bus.valid = 1'b0;
      req_bus.sample = '0;
      req_bus.pile_end = 1'b0;
      rsp_bus.ready = 1'b0;
      items_queued = 0;
      items_sent = 0;
      errors = 0;
      holds_requested = 0;
      tx_gaps_on = 1'b0;
      rx_stalls_on = 1'b0;
      med_cfg = 1'b0;
      lp_cfg = 1'b0;
      med_pile = 1'b0;
      lp_pile = 1'b0;
      raw_win[0] = '0;
      raw_win[1] = '0;
      for (int n = 0; n < 4; n++) med_win[n] = '0;
      pile_pos = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // both stages off: plain pass-through
      write_config(1'b0, 1'b0);
      queue_sample(16'hFFFF, 1'b1);
      queue_sample(16'h0000, 1'b0);
      queue_sample(16'hFFFF, 1'b1);
      settle();

      // both stages on: short piles and one past the position limit
      write_config(1'b1, 1'b1);
      queue_sample(16'h0000, 1'b1);
      queue_sample(16'hFFFF, 1'b0);
      queue_sample(16'h0000, 1'b1);
      queue_sample(16'h0000, 1'b0);
      queue_sample(16'hFFFF, 1'b0);
      queue_sample(16'h0000, 1'b1);
      queue_sample(16'hFFFF, 1'b0);
      queue_sample(16'hFFFF, 1'b0);
      queue_sample(16'h0000, 1'b0);
      queue_sample(16'hFFFF, 1'b1);
      for (int n = 0; n < 9; n++) queue_sample(n[0] ? 16'hFFFF : 16'h0000, n == 8);
      settle();

      // change the enables in the middle of a pile; the pile keeps its own
      write_config(1'b0, 1'b1);
      queue_sample(16'h1234, 1'b0);
      queue_sample(16'hFFFF, 1'b0);
      settle();
      write_config(1'b1, 1'b0);
      queue_sample(16'h0001, 1'b0);
      queue_sample(16'h8000, 1'b0);
      queue_sample(16'hFFFE, 1'b1);
      settle();

      // hold the result side off while samples keep coming
      write_config(1'b1, 1'b1);
      holds_requested++;
      first = items_queued;
      while (items_queued - first < 40) add_random_pile();
      settle();

      for (int phase = 0; items_queued < 500; phase++) begin
         if (phase < 4) begin
            write_config(phase[0], phase[1]);
         end else begin
            write_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end
         tx_gaps_on = (phase % 5) != 2;
         rx_stalls_on = (phase % 5) != 2;
         first = items_queued;
         while (items_queued - first < 50) add_random_pile();
         settle();
      end

      if (errors == 0) begin
         $display("median_lowpass_pile_filter_top regression: pass");
      end else begin
         $display("median_lowpass_pile_filter_top regression: fail");
      end
      $finish;
   end

endmodule
`default_nettype wire

// File: sim.f
src/mlpf_pkg.sv
src/mlpf_if.sv
src/mlpf_drain.sv
src/median_lowpass_pile_filter_top.sv
verif/tb_median_lowpass_pile_filter_top.sv
